/* rtl/core/imu_frame_decoder_macros.svh */
// Assertion macros used by the IMU frame decoder top level.
`ifndef IMU_FRAME_DECODER_MACROS_SVH
`define IMU_FRAME_DECODER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define IMUFD_ASSERT_NOW(label, clk_sig, rst_n_sig, pre, post) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (pre) |-> (post)) \
		else $error("imufd: same-cycle check failed");

// Next-cycle implication
`define IMUFD_ASSERT_NEXT(label, clk_sig, rst_n_sig, pre, post) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (pre) |=> (post)) \
		else $error("imufd: next-cycle check failed");

`else

`define IMUFD_ASSERT_NOW(label, clk_sig, rst_n_sig, pre, post)
`define IMUFD_ASSERT_NEXT(label, clk_sig, rst_n_sig, pre, post)

`endif

`endif

/* rtl/core/imufd_pkg.sv */
// Constants and types shared by the IMU frame decoder modules.
package imufd_pkg;

	// Frame layout
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam int         FRAME_LEN  = 11;
	localparam int         POS_W      = 4;
	localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LEN - 1);
	localparam int         STORE_DEPTH = FRAME_LEN - 2;

	// Result kinds
	localparam int         KIND_W     = 2;
	localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

	// Field widths
	localparam int RAW_W   = 16;
	localparam int VALUE_W = 32;
	localparam int TEMP_W  = 26;
	localparam int SCALE_W = 24;

	// Scaling constants
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd80336;
	localparam logic [SCALE_W-1:0] GYRO_MUL    = 24'd4000;
	localparam logic [SCALE_W-1:0] ANGLE_MUL   = 24'd360;
	localparam int PROD_W = RAW_W + SCALE_W + 1;
	localparam int ROUND_SHIFT = 8;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(128);

	// raw*65536/100 == raw*16384/25; ceil(2^34/25) is exact for |raw| <= 32768
	localparam int RECIP_W = 30;
	localparam logic [RECIP_W-1:0] TEMP_RECIP = 30'd687194768;
	localparam int TPROD_W = RAW_W + RECIP_W;
	localparam int TEMP_SHIFT = 20;

	// APB register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_ACCEL_SCALE = APB_ADDR_W'(0);

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
		logic signed [RAW_W-1:0] raw_t;
	} raw_frame_t;

endpackage

/* rtl/core/imufd_byte_if.sv */
// Byte stream channel carrying received serial bytes.
interface imufd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/imufd_result_if.sv */
// Result channel carrying one scaled IMU sample.
interface imufd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [imufd_pkg::KIND_W-1:0]          frame_kind;
	logic signed [imufd_pkg::VALUE_W-1:0]  value_x;
	logic signed [imufd_pkg::VALUE_W-1:0]  value_y;
	logic signed [imufd_pkg::VALUE_W-1:0]  value_z;
	logic signed [imufd_pkg::TEMP_W-1:0]   temperature;

	modport source (output valid, output frame_kind, output value_x, output value_y,
		output value_z, output temperature, input ready);
	modport sink (input valid, input frame_kind, input value_x, input value_y,
		input value_z, input temperature, output ready);
endinterface

/* rtl/core/imufd_parser.sv */
// Byte-level frame parser: header hunt, byte capture, checksum and type check.
module imufd_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	imufd_byte_if.sink             rx,
	output logic                   frm_valid,
	input  logic                   frm_ready,
	output imufd_pkg::raw_frame_t  frm
);

	logic [imufd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  store_q [imufd_pkg::STORE_DEPTH];
	logic                        v_s1;
	imufd_pkg::raw_frame_t       frm_s1;

	logic                        fire;
	logic                        at_check;
	logic                        kind_ok;
	logic [imufd_pkg::KIND_W-1:0] kind;
	logic                        good;

	// Stage 1 frees up when empty or when its frame moves on
	assign rx.ready = !v_s1 || frm_ready;
	assign fire     = rx.valid && rx.ready;
	assign at_check = (pos_q == imufd_pkg::POS_CHECK);

	// Frame type decode; oldest stored byte is frame byte 1
	always_comb begin
		unique case (store_q[imufd_pkg::STORE_DEPTH-1])
			imufd_pkg::TYPE_ACCEL: begin
				kind_ok = 1'b1;
				kind    = imufd_pkg::KIND_ACCEL;
			end
			imufd_pkg::TYPE_GYRO: begin
				kind_ok = 1'b1;
				kind    = imufd_pkg::KIND_GYRO;
			end
			imufd_pkg::TYPE_ANGLE: begin
				kind_ok = 1'b1;
				kind    = imufd_pkg::KIND_ANGLE;
			end
			default: begin
				kind_ok = 1'b0;
				kind    = imufd_pkg::KIND_BAD;
			end
		endcase
	end

	assign good = fire && at_check && (rx.rx_byte == sum_q) && kind_ok;

	// Byte position and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= imufd_pkg::POS_HUNT;
			sum_q <= 8'd0;
		end else if (fire) begin
			if (pos_q == imufd_pkg::POS_HUNT) begin
				if (rx.rx_byte == imufd_pkg::HDR_BYTE) begin
					pos_q <= imufd_pkg::POS_FIRST;
					sum_q <= rx.rx_byte;
				end
			end else if (at_check) begin
				// bad sum drops the frame; hunt resumes from the next byte
				pos_q <= imufd_pkg::POS_HUNT;
			end else begin
				pos_q <= pos_q + imufd_pkg::POS_W'(1);
				sum_q <= sum_q + rx.rx_byte;
			end
		end
	end

	// Frame bytes 1..9 shift in; byte 9 ends up at tap 0
	always_ff @(posedge clk) begin
		if (fire && (pos_q != imufd_pkg::POS_HUNT) && !at_check) begin
			store_q[0] <= rx.rx_byte;
			for (int i = 1; i < imufd_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= store_q[i-1];
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= good;
		end
	end

	// Stage 1 payload: little-endian axes
	always_ff @(posedge clk) begin
		if (good) begin
			frm_s1.kind  <= kind;
			frm_s1.raw_x <= {store_q[6], store_q[7]};
			frm_s1.raw_y <= {store_q[4], store_q[5]};
			frm_s1.raw_z <= {store_q[2], store_q[3]};
			frm_s1.raw_t <= {store_q[0], store_q[1]};
		end
	end

	assign frm_valid = v_s1;
	assign frm       = frm_s1;

endmodule

/* rtl/core/imufd_scaler.sv */
// Fixed-point scaling of a checked frame: product stage, then round and output register.
module imufd_scaler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               frm_valid,
	output logic                               frm_ready,
	input  imufd_pkg::raw_frame_t              frm,
	input  logic [imufd_pkg::SCALE_W-1:0]      accel_scale,
	imufd_result_if.source                     result
);

	localparam int PW = imufd_pkg::PROD_W;
	localparam int RW = imufd_pkg::RAW_W;
	localparam int QW = imufd_pkg::TPROD_W - imufd_pkg::TEMP_SHIFT;

	logic                          v_s2;
	logic                          v_s3;
	logic                          ready_s2;
	logic                          ready_s3;

	logic [imufd_pkg::KIND_W-1:0]  kind_s2;
	logic signed [PW-1:0]          px_s2;
	logic signed [PW-1:0]          py_s2;
	logic signed [PW-1:0]          pz_s2;
	logic [imufd_pkg::TPROD_W-1:0] tprod_s2;
	logic                          tneg_s2;

	logic [imufd_pkg::KIND_W-1:0]          kind_s3;
	logic signed [imufd_pkg::VALUE_W-1:0]  vx_s3;
	logic signed [imufd_pkg::VALUE_W-1:0]  vy_s3;
	logic signed [imufd_pkg::VALUE_W-1:0]  vz_s3;
	logic signed [imufd_pkg::TEMP_W-1:0]   temp_s3;

	logic [imufd_pkg::SCALE_W-1:0] mul;
	logic signed [imufd_pkg::SCALE_W:0] mul_sgn;
	logic [RW-1:0]                 tmag;
	logic signed [PW-1:0]          rx_sum;
	logic signed [PW-1:0]          ry_sum;
	logic signed [PW-1:0]          rz_sum;
	logic signed [PW-1:0]          rx_shr;
	logic signed [PW-1:0]          ry_shr;
	logic signed [PW-1:0]          rz_shr;
	logic [QW-1:0]                 tq;
	logic signed [imufd_pkg::TEMP_W-1:0] tq_ext;

	// Per-stage flow control
	assign ready_s3  = !v_s3 || result.ready;
	assign ready_s2  = !v_s2 || ready_s3;
	assign frm_ready = ready_s2;

	// Multiplier operand by frame kind
	always_comb begin
		unique case (frm.kind)
			imufd_pkg::KIND_ACCEL: mul = accel_scale;
			imufd_pkg::KIND_GYRO:  mul = imufd_pkg::GYRO_MUL;
			default:               mul = imufd_pkg::ANGLE_MUL;
		endcase
	end
	assign mul_sgn = signed'({1'b0, mul});

	// Temperature magnitude; 0x8000 negates to 32768 as unsigned
	assign tmag = frm.raw_t[RW-1] ? RW'(-frm.raw_t) : frm.raw_t;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) v_s2 <= frm_valid;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (ready_s2 && frm_valid) begin
			kind_s2  <= frm.kind;
			px_s2    <= frm.raw_x * mul_sgn;
			py_s2    <= frm.raw_y * mul_sgn;
			pz_s2    <= frm.raw_z * mul_sgn;
			tprod_s2 <= tmag * imufd_pkg::TEMP_RECIP;
			tneg_s2  <= frm.raw_t[RW-1];
		end
	end

	// Accel: drop 8 fraction bits, round half up (floor of p + 128)
	assign rx_sum = px_s2 + imufd_pkg::ROUND_BIAS;
	assign ry_sum = py_s2 + imufd_pkg::ROUND_BIAS;
	assign rz_sum = pz_s2 + imufd_pkg::ROUND_BIAS;
	assign rx_shr = rx_sum >>> imufd_pkg::ROUND_SHIFT;
	assign ry_shr = ry_sum >>> imufd_pkg::ROUND_SHIFT;
	assign rz_shr = rz_sum >>> imufd_pkg::ROUND_SHIFT;

	// Temperature quotient, sign restored (truncation toward zero)
	assign tq     = tprod_s2[imufd_pkg::TPROD_W-1:imufd_pkg::TEMP_SHIFT];
	assign tq_ext = imufd_pkg::TEMP_W'(tq);

	// Stage 3: output register
	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			kind_s3 <= kind_s2;
			if (kind_s2 == imufd_pkg::KIND_ACCEL) begin
				vx_s3   <= rx_shr[imufd_pkg::VALUE_W-1:0];
				vy_s3   <= ry_shr[imufd_pkg::VALUE_W-1:0];
				vz_s3   <= rz_shr[imufd_pkg::VALUE_W-1:0];
				temp_s3 <= tneg_s2 ? -tq_ext : tq_ext;
			end else begin
				vx_s3   <= px_s2[imufd_pkg::VALUE_W-1:0];
				vy_s3   <= py_s2[imufd_pkg::VALUE_W-1:0];
				vz_s3   <= pz_s2[imufd_pkg::VALUE_W-1:0];
				temp_s3 <= '0;
			end
		end
	end

	assign result.valid       = v_s3;
	assign result.frame_kind  = kind_s3;
	assign result.value_x     = vx_s3;
	assign result.value_y     = vy_s3;
	assign result.value_z     = vz_s3;
	assign result.temperature = temp_s3;

endmodule

/* rtl/core/imu_frame_decoder.sv */
// IMU frame decoder top level: APB register, parser and scaler.
//
// Takes one received byte per transfer and may accept a byte in every clock cycle.
// It hunts for header 0x55, collects an 11-byte frame and checks the 8-bit sum;
// good acceleration, angular-rate and angle frames give one result, in Q16.16.
// A result passes three registers after the transfer of the frame's checksum byte:
// the parser's frame register, the register of the three axis multipliers (16 x
// 25 bits) and the temperature reciprocal multiplier, and the rounding and output
// register. Stalls on the result side fill these three registers before the byte
// side is held. accel_scale sits at APB address 0, bits 23:0, reset 80336; the
// user must write it only while no frame is in flight; the block does not enforce it.
`include "imu_frame_decoder_macros.svh"

module imu_frame_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	imufd_byte_if.sink                        rx,
	imufd_result_if.source                    result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [imufd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [imufd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [imufd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready
);

	logic [imufd_pkg::SCALE_W-1:0] scale_q;
	logic                          cfg_wr;
	logic                          cfg_hit;
	logic                          frm_valid;
	logic                          frm_ready;
	imufd_pkg::raw_frame_t         frm;

	// APB register: single word, decoded at addresses 0 to 3
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_hit = (paddr[imufd_pkg::APB_ADDR_W-1:2] ==
		imufd_pkg::ADDR_ACCEL_SCALE[imufd_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= imufd_pkg::SCALE_RESET;
		end else if (cfg_wr && cfg_hit) begin
			scale_q <= pwdata[imufd_pkg::SCALE_W-1:0];
		end
	end

	assign prdata = cfg_hit ? imufd_pkg::APB_DATA_W'(scale_q) : '0;

	// Byte parser
	imufd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	// Scaling pipeline
	imufd_scaler u_scaler (
		.clk         (clk),
		.arst_n      (arst_n),
		.frm_valid   (frm_valid),
		.frm_ready   (frm_ready),
		.frm         (frm),
		.accel_scale (scale_q),
		.result      (result)
	);

	// Checks
	`IMUFD_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_wr && cfg_hit, scale_q == $past(pwdata[imufd_pkg::SCALE_W-1:0]))
	`IMUFD_ASSERT_NEXT(a_frm_hold, clk, arst_n, frm_valid && !frm_ready, frm_valid && $stable(frm))
	`IMUFD_ASSERT_NOW(a_kind_legal, clk, arst_n, result.valid, result.frame_kind != imufd_pkg::KIND_BAD)
	`IMUFD_ASSERT_NOW(a_temp_zero, clk, arst_n, result.valid && (result.frame_kind != imufd_pkg::KIND_ACCEL), result.temperature == '0)

endmodule

/* verif/tb_imu_frame_decoder.sv */
// Self-checking testbench for the IMU frame decoder: byte stream in, scaled samples out.
`timescale 1ns / 100ps

module tb_imu_frame_decoder;

	localparam int CLK_HALF      = 10;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int IDLE_PCT      = 9;
	localparam int HOLD_AFTER    = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 95;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int NUM_PHASES    = 5;
	localparam int QUIET_PHASE   = 2;
	localparam int SPARE_PHASE   = 3;

	// Q16.16 weight of one raw LSB for rate and angle frames
	localparam int RATE_Q16  = 4000;
	localparam int ANGLE_Q16 = 360;
	localparam int CENTI     = 100;

	localparam logic [7:0] TYPE_UNKNOWN = 8'h50;
	localparam logic [imufd_pkg::APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;

	typedef struct packed {
		logic [imufd_pkg::KIND_W-1:0]          kind;
		logic signed [imufd_pkg::VALUE_W-1:0]  vx;
		logic signed [imufd_pkg::VALUE_W-1:0]  vy;
		logic signed [imufd_pkg::VALUE_W-1:0]  vz;
		logic signed [imufd_pkg::TEMP_W-1:0]   temp;
	} sample_t;

	localparam sample_t NO_WANT = '0;

	typedef struct {
		bit          noisy;
		logic [7:0]  ftype;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic [15:0] raw_z;
		logic [15:0] raw_t;
		bit          bad_sum;
		bit          typed;
		sample_t     want;
	} frame_row_t;

	// Directed frames; rows with typed set carry their sample, the rest go to the decoder model
	frame_row_t directed_rows [10] = '{
		// sensor at rest, +1.00 degC
		'{0, imufd_pkg::TYPE_ACCEL, 16'h0000, 16'h0000, 16'h0000, 16'd100, 0, 1,
			'{imufd_pkg::KIND_ACCEL, 32'h0, 32'h0, 32'h0, 26'h001_0000}},
		// noise ahead of the header, full-scale axes, coldest temperature
		'{1, imufd_pkg::TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 0, 0, NO_WANT},
		// -1.00 degC
		'{0, imufd_pkg::TYPE_ACCEL, 16'h0000, 16'h0000, 16'h0000, 16'hFF9C, 0, 1,
			'{imufd_pkg::KIND_ACCEL, 32'h0, 32'h0, 32'h0, 26'h3FF_0000}},
		// rate extremes; temperature bytes must be ignored
		'{0, imufd_pkg::TYPE_GYRO, 16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 0, 1,
			'{imufd_pkg::KIND_GYRO, 32'h07CF_F060, 32'hF830_0000, 32'h0000_0FA0, 26'h0}},
		// angle of plus and minus one LSB
		'{0, imufd_pkg::TYPE_ANGLE, 16'h0001, 16'hFFFF, 16'h0000, 16'h1234, 0, 1,
			'{imufd_pkg::KIND_ANGLE, 32'h0000_0168, 32'hFFFF_FE98, 32'h0, 26'h0}},
		'{0, imufd_pkg::TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'hFF00, 16'h00FF, 0, 0, NO_WANT},
		// checksum off by one: frame dropped
		'{0, imufd_pkg::TYPE_GYRO, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1, 0, NO_WANT},
		// good checksum, unknown type: consumed silently
		'{0, TYPE_UNKNOWN, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 0, 0, NO_WANT},
		// dropped frame full of header bytes: no resync inside it
		'{0, imufd_pkg::TYPE_ACCEL, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1, 0, NO_WANT},
		'{0, imufd_pkg::TYPE_GYRO, 16'h0010, 16'hFFF0, 16'h1234, 16'h0000, 0, 0, NO_WANT}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [imufd_pkg::APB_ADDR_W-1:0] paddr;
	logic [imufd_pkg::APB_DATA_W-1:0] pwdata;
	logic [imufd_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	imufd_byte_if   rx_ch ();
	imufd_result_if res_ch ();

	imu_frame_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Decoder model state
	logic [imufd_pkg::POS_W-1:0]   hunt_pos;
	logic [7:0]                    frame_bytes [imufd_pkg::STORE_DEPTH];
	logic [7:0]                    frame_sum;
	logic [imufd_pkg::SCALE_W-1:0] model_scale;

	sample_t pending_samples [$];
	bit  idle_on;
	bit  hold_done;
	int  bytes_sent;
	int  samples_seen;
	int  mismatches;
	int  settings_used;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	initial begin
		#TIMEOUT_NS;
		$display("Test completed with failures");
		$finish;
	end

	// Little-endian int16 whose low byte sits at frame position lo
	function automatic longint raw_word(input int lo);
		return longint'($signed({frame_bytes[lo], frame_bytes[lo - 1]}));
	endfunction

	// Advance the parser model by one byte; returns 1 when a sample is due
	function automatic bit decode_byte(input logic [7:0] b, output sample_t s);
		longint x, y, z, t;
		s = NO_WANT;
		if (hunt_pos == imufd_pkg::POS_HUNT) begin
			if (b == imufd_pkg::HDR_BYTE) begin
				frame_sum = b;
				hunt_pos  = imufd_pkg::POS_FIRST;
			end
			return 1'b0;
		end
		if (hunt_pos < imufd_pkg::POS_CHECK) begin
			frame_bytes[hunt_pos - 1] = b;
			frame_sum += b;
			hunt_pos++;
			return 1'b0;
		end
		hunt_pos = imufd_pkg::POS_HUNT;
		if (b != frame_sum)
			return 1'b0;
		x = raw_word(2);
		y = raw_word(4);
		z = raw_word(6);
		t = 0;
		case (frame_bytes[0])
			imufd_pkg::TYPE_ACCEL: begin
				// Q16.24 product down to Q16.16, round half up
				s.kind = imufd_pkg::KIND_ACCEL;
				x = (x * longint'(model_scale) + 128) >>> 8;
				y = (y * longint'(model_scale) + 128) >>> 8;
				z = (z * longint'(model_scale) + 128) >>> 8;
				t = (raw_word(8) * 65536) / CENTI;
			end
			imufd_pkg::TYPE_GYRO: begin
				s.kind = imufd_pkg::KIND_GYRO;
				x *= RATE_Q16;
				y *= RATE_Q16;
				z *= RATE_Q16;
			end
			imufd_pkg::TYPE_ANGLE: begin
				s.kind = imufd_pkg::KIND_ANGLE;
				x *= ANGLE_Q16;
				y *= ANGLE_Q16;
				z *= ANGLE_Q16;
			end
			default: return 1'b0;
		endcase
		s.vx   = x[imufd_pkg::VALUE_W-1:0];
		s.vy   = y[imufd_pkg::VALUE_W-1:0];
		s.vz   = z[imufd_pkg::VALUE_W-1:0];
		s.temp = t[imufd_pkg::TEMP_W-1:0];
		return 1'b1;
	endfunction

	// One byte transfer, with an occasional gap in front of it
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input sample_t want = NO_WANT);
		sample_t s;
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		if (decode_byte(b, s))
			pending_samples.push_back(typed ? want : s);
	endtask

	// Build an 11-byte frame, optionally corrupt its checksum or cut it short
	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] ax, ay, az, at_raw,
			input logic [7:0] sum_flip, input int cut, input bit typed = 1'b0,
			input sample_t want = NO_WANT);
		logic [7:0] fb [imufd_pkg::FRAME_LEN];
		logic [7:0] sum;
		fb = '{imufd_pkg::HDR_BYTE, ftype, ax[7:0], ax[15:8], ay[7:0], ay[15:8],
			az[7:0], az[15:8], at_raw[7:0], at_raw[15:8], 8'h00};
		sum = 8'h00;
		for (int i = 0; i < imufd_pkg::FRAME_LEN - 1; i++)
			sum += fb[i];
		fb[imufd_pkg::FRAME_LEN - 1] = sum ^ sum_flip;
		for (int i = 0; i < cut; i++)
			send_byte(fb[i], typed, want);
	endtask

	function automatic logic [15:0] pick_raw();
		logic [15:0] corners [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		if ($urandom_range(7) == 0)
			return corners[$urandom_range(3)];
		return 16'($urandom);
	endfunction

	// Stop offering bytes and let every outstanding sample drain out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [imufd_pkg::APB_ADDR_W-1:0] addr,
			input logic [imufd_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == imufd_pkg::ADDR_ACCEL_SCALE)
			model_scale = data[imufd_pkg::SCALE_W-1:0];
		@(posedge clk);
	endtask

	task automatic read_back_scale();
		logic [imufd_pkg::APB_DATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= imufd_pkg::ADDR_ACCEL_SCALE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd[imufd_pkg::SCALE_W-1:0] !== model_scale) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH accel_scale read back: exp %0d got %0d",
					model_scale, rd[imufd_pkg::SCALE_W-1:0]);
		end
	endtask

	task automatic flag_mismatch(input string what, input sample_t want, input sample_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("MISMATCH %s at %0t", what, $time);
			$display("  exp kind=%0d x=%0d y=%0d z=%0d temp=%0d",
				want.kind, want.vx, want.vy, want.vz, want.temp);
			$display("  got kind=%0d x=%0d y=%0d z=%0d temp=%0d",
				got.kind, got.vx, got.vy, got.vz, got.temp);
		end
	endtask

	// Result side: random stalls, plus one long hold that backs the block up
	initial begin
		res_ch.ready <= 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && samples_seen >= HOLD_AFTER) begin
				res_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_done = 1'b1;
			end else begin
				res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Compare each result transfer with the oldest pending sample
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			sample_t got;
			sample_t want;
			got = '{res_ch.frame_kind, res_ch.value_x, res_ch.value_y, res_ch.value_z,
				res_ch.temperature};
			samples_seen++;
			if (pending_samples.size() == 0) begin
				flag_mismatch("sample with none pending", NO_WANT, got);
			end else begin
				want = pending_samples.pop_front();
				if (got.kind !== want.kind || got.vx !== want.vx || got.vy !== want.vy ||
						got.vz !== want.vz || got.temp !== want.temp)
					flag_mismatch("sample fields", want, got);
			end
		end
	end

	// Main sequence
	initial begin
		logic [imufd_pkg::SCALE_W-1:0] phase_scale [NUM_PHASES];
		logic [7:0] frame_types [3];
		logic [7:0] ftype;
		int stop_at;
		int k;

		frame_types = '{imufd_pkg::TYPE_ACCEL, imufd_pkg::TYPE_GYRO, imufd_pkg::TYPE_ANGLE};
		phase_scale = '{imufd_pkg::SCALE_RESET, 24'hFF_FFFF, 24'd1, 24'd0,
			imufd_pkg::SCALE_W'($urandom_range(2, 24'hFF_FFFE))};

		arst_n        = 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		idle_on = 1'b1;
		bytes_sent    = 0;
		samples_seen  = 0;
		mismatches    = 0;
		settings_used = 1;
		hunt_pos    = imufd_pkg::POS_HUNT;
		frame_sum   = 8'h00;
		model_scale = imufd_pkg::SCALE_RESET;
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'h00;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset scale
		read_back_scale();
		foreach (directed_rows[i]) begin
			if (directed_rows[i].noisy) begin
				send_byte(8'h00);
				send_byte(8'hFF);
				send_byte(8'h54);
			end
			send_frame(directed_rows[i].ftype, directed_rows[i].raw_x, directed_rows[i].raw_y,
				directed_rows[i].raw_z, directed_rows[i].raw_t,
				directed_rows[i].bad_sum ? 8'h01 : 8'h00, imufd_pkg::FRAME_LEN,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Random frames, one accel_scale setting per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				apb_write(imufd_pkg::ADDR_ACCEL_SCALE, {8'($urandom), phase_scale[ph]});
				if (ph == SPARE_PHASE)
					apb_write(ADDR_SPARE, imufd_pkg::APB_DATA_W'($urandom));
				read_back_scale();
				settings_used++;
			end
			idle_on = (ph != QUIET_PHASE);
			stop_at = bytes_sent + PHASE_BYTES;
			while (bytes_sent < stop_at) begin
				// stray line noise between frames now and then
				if ($urandom_range(99) < 10)
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
				k = $urandom_range(9);
				ftype = (k < 9) ? frame_types[k / 3] : 8'($urandom);
				send_frame(ftype, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
					($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00,
					($urandom_range(99) < 5) ? $urandom_range(1, imufd_pkg::FRAME_LEN - 1)
						: imufd_pkg::FRAME_LEN);
			end
			// finish any frame still open so the next setting lands between frames
			while (hunt_pos != imufd_pkg::POS_HUNT)
				send_byte(8'($urandom));
		end
		drain();

		$display("Sent %0d bytes over %0d accel_scale settings (incl. zero and full scale).",
			bytes_sent, settings_used);
		$display("Checked %0d decoded samples; long result hold applied: %0d.",
			samples_seen, hold_done);
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/imufd_pkg.sv
rtl/core/imufd_byte_if.sv
rtl/core/imufd_result_if.sv
rtl/core/imufd_parser.sv
rtl/core/imufd_scaler.sv
rtl/core/imu_frame_decoder.sv
verif/tb_imu_frame_decoder.sv
